// ===== sv/radical_inverse_any_base_core_assert.svh =====
// ----------------------------------------------------------------------------
// Radical inverse core assertion macros
// Clocked assertion shorthands shared by the core's modules.
// ----------------------------------------------------------------------------
`ifndef RADICAL_INVERSE_ANY_BASE_CORE_ASSERT_SVH
`define RADICAL_INVERSE_ANY_BASE_CORE_ASSERT_SVH

// checked outside reset
`define RIAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("riab assertion failed");

// checked in and out of reset
`define RIAB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("riab assertion failed");

`endif

// ===== sv/riab_pkg.sv =====
// ----------------------------------------------------------------------------
// Radical inverse package
// Widths and the request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package riab_pkg;

  localparam int INDEX_BITS = 31;
  localparam int BASE_BITS  = 10;
  localparam int FRAC_BITS  = 32;
  // denominator is base^digits <= index * base
  localparam int DEN_W      = INDEX_BITS + BASE_BITS;
  localparam int CNT_W      = $clog2(FRAC_BITS);

  typedef struct packed {
    logic                 start;
    logic [DEN_W-1:0]     rem_init;
    logic [FRAC_BITS-1:0] dividend;
    logic [DEN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [FRAC_BITS-1:0] quotient;
    logic [DEN_W-1:0]     remainder;
  } div_rsp_t;

endpackage

// ===== sv/riab_div.sv =====
// ----------------------------------------------------------------------------
// Radical inverse shared divider
// Restoring divider, one quotient bit per cycle, FRAC_BITS steps per run.
// Serves both digit extraction and the final fraction division.
// ----------------------------------------------------------------------------
`include "radical_inverse_any_base_core_assert.svh"

module riab_div (
  input  logic              clk,
  input  logic              rst,
  input  riab_pkg::div_req_t req,
  output riab_pkg::div_rsp_t rsp
);
  import riab_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DEN_W-1:0]     rem;
  logic [FRAC_BITS-1:0] dvd;
  logic [FRAC_BITS-1:0] quo;

  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 qbit;
  logic [DEN_W-1:0]     rem_next;

  always_comb begin
    trial    = {rem, dvd[FRAC_BITS-1]};
    diff     = trial - {1'b0, req.divisor};
    qbit     = (trial >= {1'b0, req.divisor});
    rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[FRAC_BITS-2:0], 1'b0};
      quo <= {quo[FRAC_BITS-2:0], qbit};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = busy && (cnt == CNT_LAST);
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  `RIAB_ASSERT(a_start_idle, req.start |-> !busy)
  `RIAB_ASSERT(a_start_runs, req.start |=> busy && (cnt == '0))
  `RIAB_ASSERT(a_done_ends, rsp.done |=> !busy)

endmodule

// ===== sv/radical_inverse_any_base_core.sv =====
// ----------------------------------------------------------------------------
// Radical inverse core
// Van der Corput radical inverse of an index in any base, as a 32-bit fraction.
// ----------------------------------------------------------------------------
// Input channel: sample_index and digit_base, taken when in_valid and
// in_ready are both high. Output channel: fraction and bad_base, one word
// per input word, handed over when out_valid and out_ready are both high.
// One word is worked on at a time; in_ready is high only while idle.
// Every digit of the index costs one run of the shared restoring divider
// plus sequencing (operand setup and the multiply step); the final fraction
// takes one more run. A base below 2 skips the divider: out_valid rises
// with bad_base set and fraction zero. An index of zero goes straight to
// the final fraction run and gives fraction zero.
// The finished word sits in an output register. While the receiver stalls
// the core still takes one more word and works it, then holds it with
// in_ready low until the waiting word is taken.
// Reset (synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
`include "radical_inverse_any_base_core_assert.svh"

module radical_inverse_any_base_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [riab_pkg::INDEX_BITS-1:0]     sample_index,
  input  logic [riab_pkg::BASE_BITS-1:0]      digit_base,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [riab_pkg::FRAC_BITS-1:0]      fraction,
  output logic                                bad_base
);
  import riab_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FRAC = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]            state;
  logic [INDEX_BITS-1:0] idx;
  logic [BASE_BITS-1:0]  base;
  logic [DEN_W-1:0]      num;
  logic [DEN_W-1:0]      den;
  logic                  bad;

  logic [DEN_W+BASE_BITS-1:0] num_prod;
  logic [DEN_W+BASE_BITS-1:0] den_prod;

  div_req_t req;
  div_rsp_t rsp;

  riab_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_ready = (state == S_IDLE);

  // next digit or final fraction
  always_comb begin
    req.start = (state == S_NEXT);
    if (idx == '0) begin
      req.rem_init = num;
      req.dividend = '0;
      req.divisor  = den;
    end else begin
      req.rem_init = '0;
      req.dividend = FRAC_BITS'(idx);
      req.divisor  = DEN_W'(base);
    end
  end

  assign num_prod = num * base;
  assign den_prod = den * base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (digit_base < BASE_BITS'(2)) ? S_FIN : S_NEXT;
          end
        end
        S_NEXT: begin
          state <= (idx == '0) ? S_FRAC : S_DIV;
        end
        S_DIV: begin
          if (rsp.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_NEXT;
        end
        S_FRAC: begin
          if (rsp.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      idx  <= sample_index;
      base <= digit_base;
      num  <= '0;
      den  <= DEN_W'(1);
      bad  <= (digit_base < BASE_BITS'(2));
    end else if (state == S_MUL) begin
      // num = num*base + digit, den = den*base, idx = idx/base
      num <= num_prod[DEN_W-1:0] + rsp.remainder;
      den <= den_prod[DEN_W-1:0];
      idx <= rsp.quotient[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      fraction <= bad ? '0 : rsp.quotient;
      bad_base <= bad;
    end
  end

  `RIAB_ASSERT_ALWAYS(a_rst_clears, rst |=> !out_valid && (state == S_IDLE))
  `RIAB_ASSERT(a_bad_zero, out_valid && bad_base |-> fraction == '0)
  `RIAB_ASSERT(a_idle_no_div, in_ready |-> !rsp.busy)
  `RIAB_ASSERT(a_done_in_run, rsp.done |-> (state == S_DIV) || (state == S_FRAC))

endmodule

// ===== tb/sv/radical_inverse_any_base_core_tb.sv =====
// ----------------------------------------------------------------------------
// Radical inverse core testbench
// Drives index/base words through the valid/ready input, predicts each digit-
// reversed fraction with a local model, and checks every output word in order.
// Random gaps on both sides, quiet stretches, and long receiver hold-offs.
// ----------------------------------------------------------------------------
module radical_inverse_any_base_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import riab_pkg::*;

  typedef struct {
    logic [INDEX_BITS-1:0] idx;
    logic [BASE_BITS-1:0]  base;
  } index_word_t;

  typedef struct {
    logic [FRAC_BITS-1:0] fraction;
    logic                 bad;
  } inverse_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [INDEX_BITS-1:0] sample_index = '0;
  logic [BASE_BITS-1:0]  digit_base = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FRAC_BITS-1:0]  fraction;
  logic                  bad_base;

  index_word_t index_words[$];
  inverse_t    expected_inverse[$];

  int words_checked = 0;
  int bad_words = 0;
  int mismatches = 0;
  int holdoffs = 0;
  int in_gap = 0;
  int in_quiet = 0;
  int out_gap = 0;
  int out_quiet = 0;
  int hold_left = 0;
  int stall_seen = 0;

  radical_inverse_any_base_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_index(sample_index),
    .digit_base(digit_base),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fraction(fraction),
    .bad_base(bad_base)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // digit reversal, then 32-bit restoring division of numerator by base^digits
  function automatic inverse_t van_der_corput(input logic [INDEX_BITS-1:0] idx,
                                              input logic [BASE_BITS-1:0] base);
    inverse_t    res;
    logic [63:0] n;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    res.fraction = '0;
    res.bad = (base < 2);
    if (!res.bad) begin
      n = 64'(idx);
      b = 64'(base);
      num = '0;
      den = 64'd1;
      while (n != 0) begin
        num = num * b + (n % b);
        den = den * b;
        n = n / b;
      end
      r = num;
      for (int k = 0; k < FRAC_BITS; k++) begin
        r = r << 1;
        res.fraction = {res.fraction[FRAC_BITS-2:0], 1'b0};
        if (r >= den) begin
          r = r - den;
          res.fraction[0] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // random gap between words, with occasional runs of back-to-back words
  function automatic int draw_gap(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      quiet_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic add_word(input logic [INDEX_BITS-1:0] idx,
                          input logic [BASE_BITS-1:0] base);
    index_word_t w;
    w.idx = idx;
    w.base = base;
    index_words.push_back(w);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = draw_gap(in_quiet);
    end else begin
      if (in_valid && in_ready) begin
        expected_inverse.push_back(van_der_corput(index_words[0].idx, index_words[0].base));
        void'(index_words.pop_front());
        in_gap = draw_gap(in_quiet);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || index_words.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          sample_index <= index_words[0].idx;
          digit_base <= index_words[0].base;
        end
      end
    end
  end

  // long stall: input backs up behind the held output word
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) stall_seen++;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (out_valid && out_ready && (stall_seen == 150 || stall_seen == 420)) begin
        hold_left <= 3000;
        holdoffs++;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    inverse_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = draw_gap(out_quiet);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_inverse.size() == 0) begin
          $error("output word with none expected: fraction=%h bad_base=%b",
                 fraction, bad_base);
          mismatches++;
        end else begin
          exp_w = expected_inverse.pop_front();
          if (fraction !== exp_w.fraction) begin
            $error("fraction: expected %h, got %h", exp_w.fraction, fraction);
            mismatches++;
          end
          if (bad_base !== exp_w.bad) begin
            $error("bad_base: expected %b, got %b", exp_w.bad, bad_base);
            mismatches++;
          end
          if (exp_w.bad) bad_words++;
        end
        words_checked++;
        out_gap = draw_gap(out_quiet);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [INDEX_BITS-1:0] idx;
    logic [BASE_BITS-1:0]  base;
    int                    w;
    int                    sel;

    // directed: zero index, invalid bases, extreme indexes and bases
    add_word('0, 10'd2);
    add_word('0, 10'd0);
    add_word('0, 10'd1);
    add_word('1, 10'd0);
    add_word('1, 10'd1);
    add_word(31'd12345, 10'd1);
    add_word('1, 10'd2);
    add_word('1, 10'd3);
    add_word('1, 10'd7);
    add_word('1, 10'd512);
    add_word('1, 10'd1023);
    add_word(31'd1, 10'd2);
    add_word(31'd1, 10'd3);
    add_word(31'd2, 10'd3);
    add_word(31'd1, 10'd1023);
    add_word(31'd1022, 10'd1023);
    add_word(31'd1023, 10'd1023);
    add_word(31'd1024, 10'd1023);
    add_word(31'h4000_0000, 10'd2);
    add_word(31'h5555_5555, 10'd2);
    add_word(31'd123456789, 10'd10);
    add_word(31'd5, 10'd3);
    add_word(31'h2AAA_AAAA, 10'd1022);

    for (int i = 0; i < 560; i++) begin
      w = $urandom_range(1, INDEX_BITS);
      idx = INDEX_BITS'($urandom);
      idx = idx & INDEX_BITS'((32'd1 << w) - 1);
      if ($urandom_range(0, 19) == 0) idx = '0;
      sel = $urandom_range(0, 99);
      if (sel < 6) base = BASE_BITS'($urandom_range(0, 1));
      else if (sel < 40) base = BASE_BITS'($urandom_range(2, 16));
      else if (sel < 55) base = 10'd1 << $urandom_range(1, 9);
      else base = BASE_BITS'($urandom_range(0, 1023));
      add_word(idx, base);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (index_words.size() != 0 || expected_inverse.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("checked %0d output words (%0d with an invalid base), %0d long receiver stalls",
             words_checked, bad_words, holdoffs);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("timeout with %0d words unsent and %0d outstanding",
             index_words.size(), expected_inverse.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
